// ----- hw/rtl/bvd_pkg.sv -----
// ---------------------------------------------------------------------------
// bvd_pkg - shared types and constants for the BPSK varicode decoder
// Holds the varicode code table, payload widths, register reset values and
// the reverse lookup from a gathered code to its character.
// ---------------------------------------------------------------------------
`default_nettype none

package bvd_pkg;

    // Payload and register widths
    localparam int unsigned SPS_W             = 16;
    localparam int unsigned CHAR_W            = 8;
    localparam int unsigned VC_CODE_W         = 10;
    localparam int unsigned TABLE_ENTRIES     = 128;
    localparam int unsigned MAX_CODE_BITS_DEF = 16;

    localparam logic [SPS_W-1:0] SPS_RESET = 16'd1536;

    typedef logic [SPS_W-1:0]     t_sps;
    typedef logic [CHAR_W-1:0]    t_char;
    typedef logic [VC_CODE_W-1:0] t_vc_code;

    typedef struct packed {
        logic  hit;
        t_char index;
    } t_vc_match;

    // Varicode words, indexed by character code
    localparam t_vc_code VC_TABLE [TABLE_ENTRIES] = '{
        10'h2AB, 10'h2DB, 10'h2ED, 10'h377, 10'h2EB, 10'h35F, 10'h2EF, 10'h2FD,
        10'h2FF, 10'h0EF, 10'h01D, 10'h36F, 10'h2DD, 10'h01F, 10'h375, 10'h3AB,
        10'h2F7, 10'h2F5, 10'h3AD, 10'h3AF, 10'h35B, 10'h36B, 10'h36D, 10'h357,
        10'h37B, 10'h37D, 10'h3B7, 10'h355, 10'h35D, 10'h3BB, 10'h2FB, 10'h37F,
        10'h001, 10'h1FF, 10'h15F, 10'h1F5, 10'h1DB, 10'h2D5, 10'h2BB, 10'h17F,
        10'h0FB, 10'h0F7, 10'h16F, 10'h1DF, 10'h075, 10'h035, 10'h057, 10'h1AF,
        10'h0B7, 10'h0BD, 10'h0ED, 10'h0FF, 10'h177, 10'h15B, 10'h16B, 10'h1AD,
        10'h1AB, 10'h1B7, 10'h0F5, 10'h1BD, 10'h1ED, 10'h055, 10'h1D7, 10'h2AF,
        10'h2BD, 10'h07D, 10'h0EB, 10'h0AD, 10'h0B5, 10'h077, 10'h0DB, 10'h0FD,
        10'h155, 10'h07F, 10'h1FD, 10'h17D, 10'h0D7, 10'h0BB, 10'h0DD, 10'h0AB,
        10'h0D5, 10'h1DD, 10'h0AF, 10'h06F, 10'h06D, 10'h157, 10'h1B5, 10'h15D,
        10'h175, 10'h17B, 10'h2AD, 10'h1F7, 10'h1EF, 10'h1FB, 10'h2BF, 10'h16D,
        10'h2DF, 10'h00B, 10'h05F, 10'h02F, 10'h02D, 10'h003, 10'h03D, 10'h05B,
        10'h02B, 10'h00D, 10'h1EB, 10'h0BF, 10'h01B, 10'h03B, 10'h00F, 10'h007,
        10'h03F, 10'h1BF, 10'h015, 10'h017, 10'h005, 10'h037, 10'h07B, 10'h06B,
        10'h0DF, 10'h05D, 10'h1D5, 10'h2B7, 10'h1BB, 10'h2B5, 10'h2D7, 10'h3B5
    };

    // Reverse lookup: compare against every entry, lowest index wins
    function automatic t_vc_match vc_lookup(input t_vc_code code);
        t_vc_match m;
        m = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (VC_TABLE[i] == code) begin
                m.hit   = 1'b1;
                m.index = CHAR_W'(i);
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bvd_sample_if.sv -----
// ---------------------------------------------------------------------------
// bvd_sample_if - in-phase sign sample channel
// One beat carries the sign of one in-phase sample.
// ---------------------------------------------------------------------------
`default_nettype none

interface bvd_sample_if;
    logic valid;
    logic ready;
    logic in_phase_nonnegative;

    modport source (output valid, output in_phase_nonnegative, input ready);
    modport sink   (input valid, input in_phase_nonnegative, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bvd_cfg_if.sv -----
// ---------------------------------------------------------------------------
// bvd_cfg_if - configuration write channel
// One beat writes the samples-per-symbol register.
// ---------------------------------------------------------------------------
`default_nettype none

interface bvd_cfg_if;
    logic          valid;
    logic          ready;
    bvd_pkg::t_sps samples_per_symbol;

    modport source (output valid, output samples_per_symbol, input ready);
    modport sink   (input valid, input samples_per_symbol, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bvd_char_if.sv -----
// ---------------------------------------------------------------------------
// bvd_char_if - decoded character channel
// One beat carries one decoded character.
// ---------------------------------------------------------------------------
`default_nettype none

interface bvd_char_if;
    logic           valid;
    logic           ready;
    bvd_pkg::t_char rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bpsk_varicode_symbol_decoder.sv -----
// Path: a character is offered from the result register, which takes the
//   request registered on the beat with the second zero of its delimiter.
// Throughput: one sample beat per cycle; the only stall is a table lookup
//   waiting behind an untaken result.
// Reset: synchronous, active low; clears timing and code state, sets the
//   period to 1536 samples. No clearing pass.
// ---------------------------------------------------------------------------
// bpsk_varicode_symbol_decoder - BPSK symbol slicer and varicode decoder
// Samples the in-phase sign once per symbol, decodes differential bits and
// turns complete varicode words into characters.
// ---------------------------------------------------------------------------
`default_nettype none

module bpsk_varicode_symbol_decoder #(
    parameter int unsigned MAX_CODE_BITS = bvd_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bvd_sample_if.sink  i_sample,
    bvd_cfg_if.sink     i_cfg,
    bvd_char_if.source  o_char
);

    logic                     w_req_valid;
    logic                     w_req_take;
    logic [MAX_CODE_BITS-1:0] w_req_code;

    // Symbol timing and code gathering
    bvd_symbol_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_sample),
        .i_cfg       (i_cfg),
        .i_req_take  (w_req_take),
        .o_req_valid (w_req_valid),
        .o_req_code  (w_req_code)
    );

    // Table match and result beat
    bvd_lookup #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_lookup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req_code  (w_req_code),
        .o_req_take  (w_req_take),
        .o_char      (o_char)
    );

    // A waiting request blocks new samples
    a_req_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_valid && !w_req_take) |-> !i_sample.ready)
        else $error("sample accepted while a lookup request waits");

    // A waiting request keeps its code
    a_req_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_valid && !w_req_take) |=> (w_req_valid && $stable(w_req_code)))
        else $error("lookup request lost or changed while waiting");

    // A new result only follows a taken request
    a_result_from_req : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char.valid && o_char.ready && !w_req_take) |=> !o_char.valid)
        else $error("result beat without a lookup request");

endmodule

`default_nettype wire

// ----- hw/rtl/bvd_symbol_front.sv -----
// ---------------------------------------------------------------------------
// bvd_symbol_front - symbol timing, bit slicer and code gatherer
// Counts samples per symbol, turns sign reversals into bits, gathers bits
// until a double zero and registers a lookup request for a usable code.
// ---------------------------------------------------------------------------
`default_nettype none

module bvd_symbol_front #(
    parameter int unsigned MAX_CODE_BITS = bvd_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    bvd_sample_if.sink                    i_sample,
    bvd_cfg_if.sink                       i_cfg,
    input  wire logic                     i_req_take,
    output logic                          o_req_valid,
    output logic [MAX_CODE_BITS-1:0]      o_req_code
);

    localparam int unsigned SPS_W = bvd_pkg::SPS_W;
    localparam int unsigned LEN_W = $clog2(MAX_CODE_BITS + 1);
    localparam int unsigned IDX_W = $clog2(MAX_CODE_BITS);

    bvd_pkg::t_sps              r_sps;
    bvd_pkg::t_sps              r_count,     n_count;
    logic                       r_last,      n_last;
    logic                       r_zero_run,  n_zero_run;
    logic [MAX_CODE_BITS-1:0]   r_bits,      n_bits;
    logic [LEN_W-1:0]           r_len,       n_len;
    logic                       r_ovf,       n_ovf;
    logic                       r_req_valid, n_req_valid;
    logic [MAX_CODE_BITS-1:0]   r_req_code,  n_req_code;

    logic               w_accept;
    logic [SPS_W:0]     w_count_inc;
    logic [SPS_W:0]     w_count_wrap;
    logic               w_sample_due;
    logic               w_same_sign;
    logic               w_delimiter;
    logic [LEN_W-1:0]   w_len_m1;
    logic               w_top_bit;
    logic               w_req_ok;
    logic               w_push_room;

    // Hold off new samples while a lookup request waits
    assign i_sample.ready = !r_req_valid || i_req_take;
    assign w_accept       = i_sample.valid && i_sample.ready;
    assign i_cfg.ready    = 1'b1;

    // Symbol timing
    assign w_count_inc  = {1'b0, r_count} + (SPS_W + 1)'(1);
    assign w_count_wrap = w_count_inc - {1'b0, r_sps};
    assign w_sample_due = (w_count_inc >= {1'b0, r_sps});

    // Bit slicing and delimiter detection
    assign w_same_sign = (i_sample.in_phase_nonnegative == r_last);
    assign w_delimiter = !w_same_sign && r_zero_run;

    // A code is worth looking up when it has more than the delimiter bit,
    // did not overflow and starts with a one
    assign w_len_m1    = r_len - LEN_W'(1);
    assign w_top_bit   = r_bits[w_len_m1[IDX_W-1:0]];
    assign w_req_ok    = (r_len > LEN_W'(1)) && !r_ovf && w_top_bit;
    assign w_push_room = (r_len < LEN_W'(MAX_CODE_BITS));

    // Next state for one accepted sample
    always_comb begin
        n_count     = r_count;
        n_last      = r_last;
        n_zero_run  = r_zero_run;
        n_bits      = r_bits;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_req_valid = r_req_valid && !i_req_take;
        n_req_code  = r_req_code;

        if (w_accept) begin
            if (!w_sample_due) begin
                n_count = w_count_inc[SPS_W-1:0];
            end else begin
                n_count = (r_sps == '0) ? '0 : w_count_wrap[SPS_W-1:0];
                n_last  = i_sample.in_phase_nonnegative;
                if (w_delimiter) begin
                    // drop the delimiter zero and clear the code
                    n_req_valid = w_req_ok;
                    n_req_code  = r_bits >> 1;
                    n_bits      = '0;
                    n_len       = '0;
                    n_ovf       = 1'b0;
                    n_zero_run  = 1'b0;
                end else begin
                    n_zero_run = !w_same_sign;
                    if (w_push_room) begin
                        n_bits = {r_bits[MAX_CODE_BITS-2:0], w_same_sign};
                        n_len  = r_len + LEN_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps       <= bvd_pkg::SPS_RESET;
            r_count     <= '0;
            r_last      <= 1'b1;
            r_zero_run  <= 1'b0;
            r_bits      <= '0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_req_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_sps <= i_cfg.samples_per_symbol;
            end
            r_count     <= n_count;
            r_last      <= n_last;
            r_zero_run  <= n_zero_run;
            r_bits      <= n_bits;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_req_valid <= n_req_valid;
        end
    end

    // Request payload
    always_ff @(posedge i_clk) begin
        r_req_code <= n_req_code;
    end

    assign o_req_valid = r_req_valid;
    assign o_req_code  = r_req_code;

endmodule

`default_nettype wire

// ----- hw/rtl/bvd_lookup.sv -----
// ---------------------------------------------------------------------------
// bvd_lookup - varicode table match and result register
// Matches a requested code against the table and holds the character until
// the sink takes the beat.
// ---------------------------------------------------------------------------
`default_nettype none

module bvd_lookup #(
    parameter int unsigned MAX_CODE_BITS = bvd_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_req_valid,
    input  wire logic [MAX_CODE_BITS-1:0] i_req_code,
    output logic                          o_req_take,
    bvd_char_if.source                    o_char
);

    localparam int unsigned VC_CODE_W = bvd_pkg::VC_CODE_W;

    logic                 r_out_valid;
    bvd_pkg::t_char       r_char;
    bvd_pkg::t_vc_match   w_match;
    logic                 w_hit;

    // Compare the low bits, upper bits must be clear
    assign w_match = bvd_pkg::vc_lookup(i_req_code[VC_CODE_W-1:0]);
    assign w_hit   = w_match.hit && (i_req_code[MAX_CODE_BITS-1:VC_CODE_W] == '0);

    // Take a request whenever the result slot is free or draining
    assign o_req_take = i_req_valid && (!r_out_valid || o_char.ready);

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_char.ready) begin
            r_out_valid <= i_req_valid && w_hit;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_req_take) begin
            r_char <= w_match.index;
        end
    end

    assign o_char.valid   = r_out_valid;
    assign o_char.rx_char = r_char;

endmodule

`default_nettype wire
